/* sv/sorted_set_search_insert_remove_defines.svh */
// assertion macros for the sorted set block
`ifndef SORTED_SET_SEARCH_INSERT_REMOVE_DEFINES_SVH
`define SORTED_SET_SEARCH_INSERT_REMOVE_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define SSIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication outside reset
`define SSIR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SSIR_ASSERT(lbl, prop, msg)
`define SSIR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

/* sv/ssir_pkg.sv */
// shared types and codes of the sorted set block
package ssir_pkg;

  // request codes; code 3 is unused and answers not found
  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // result codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // index register operations
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_INC,
    IDX_DEC,
    IDX_LOAD_CNT
  } idx_op_e;

  // count register operations
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // memory read address select
  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1
  } rd_sel_e;

  // memory write data select
  typedef enum logic {
    WR_RDATA,
    WR_KEY
  } wr_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    key_ld;
    idx_op_e idx_op;
    cnt_op_e cnt_op;
    logic    pos_ld;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       lt;        // entry read is below the key
    logic       eq;        // entry read equals the key
    logic       scan_end;  // index reached the count
    logic       full;      // count equals capacity
    logic       idx_gt_pos;
    logic       rem_more;  // index + 1 below the count
    logic [6:0] cnt7;
  } stat_t;

endpackage

/* sv/ssir_datapath.sv */
// datapath of the sorted set: entry memory, count, index and key registers
`include "sorted_set_search_insert_remove_defines.svh"

module ssir_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] item_value_i,
  input  ssir_pkg::cmd_t     cmd_i,
  output ssir_pkg::stat_t    stat_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_q;
  logic signed [31:0] key_q;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      pos_q;
  logic [CW-1:0]      rd_idx;
  logic signed [31:0] wr_data;
  logic [CW:0]        idx_p1_ext;

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      ssir_pkg::RD_IDX:    rd_idx = idx_q;
      ssir_pkg::RD_IDX_M1: rd_idx = idx_q - CW'(1);
      ssir_pkg::RD_IDX_P1: rd_idx = idx_q + CW'(1);
      default:             rd_idx = idx_q;
    endcase
  end

  assign wr_data = (cmd_i.wr_sel == ssir_pkg::WR_KEY) ? key_q : rdata_q;

  // entry memory, one read or one write a cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[idx_q[IW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_idx[IW-1:0]];
    end
  end

  // key and lower bound position
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_ld) begin
      key_q <= item_value_i;
    end
    if (cmd_i.pos_ld) begin
      pos_q <= idx_q;
    end
  end

  // index next value
  always_comb begin
    case (cmd_i.idx_op)
      ssir_pkg::IDX_HOLD:     idx_d = idx_q;
      ssir_pkg::IDX_CLEAR:    idx_d = '0;
      ssir_pkg::IDX_INC:      idx_d = idx_q + CW'(1);
      ssir_pkg::IDX_DEC:      idx_d = idx_q - CW'(1);
      ssir_pkg::IDX_LOAD_CNT: idx_d = cnt_q;
      default:                idx_d = idx_q;
    endcase
  end

  // count next value
  always_comb begin
    case (cmd_i.cnt_op)
      ssir_pkg::CNT_HOLD: cnt_d = cnt_q;
      ssir_pkg::CNT_INC:  cnt_d = cnt_q + CW'(1);
      ssir_pkg::CNT_DEC:  cnt_d = cnt_q - CW'(1);
      default:            cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  // status to the controller
  assign idx_p1_ext        = {1'b0, idx_q} + (CW+1)'(1);
  assign stat_o.lt         = rdata_q < key_q;
  assign stat_o.eq         = rdata_q == key_q;
  assign stat_o.scan_end   = idx_q == cnt_q;
  assign stat_o.full       = cnt_q == CW'(CAPACITY);
  assign stat_o.idx_gt_pos = idx_q > pos_q;
  assign stat_o.rem_more   = idx_p1_ext < {1'b0, cnt_q};
  assign stat_o.cnt7       = 7'(cnt_q);

  `SSIR_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY), "count above capacity")
  `SSIR_ASSERT_IMPL(a_no_overflow, cmd_i.cnt_op == ssir_pkg::CNT_INC,
    cnt_q < CW'(CAPACITY), "insert into a full store")
  `SSIR_ASSERT_IMPL(a_no_underflow, cmd_i.cnt_op == ssir_pkg::CNT_DEC,
    cnt_q != '0, "remove from an empty store")
  `SSIR_ASSERT_IMPL(a_wr_range, cmd_i.wr_en, idx_q < CW'(CAPACITY),
    "write past the last entry")

endmodule

/* sv/ssir_ctrl.sv */
// controller of the sorted set: request sequencing and result register
module ssir_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [1:0]      op_i,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic [1:0]      status_o,
  output logic [6:0]      count_o,
  output ssir_pkg::cmd_t  cmd_o,
  input  ssir_pkg::stat_t stat_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_CHK,
    S_SCAN_CMP,
    S_DECIDE,
    S_INS_CHK,
    S_INS_WR,
    S_REM_CHK,
    S_REM_WR,
    S_RESULT
  } state_e;

  state_e              state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic                held_q, held_d;
  ssir_pkg::status_e   res_q, res_d;
  logic                m_valid_q, m_valid_d;
  ssir_pkg::status_e   status_q, status_d;
  logic [6:0]          count_q, count_d;

  assign s_ready_o = state_q == S_IDLE;
  assign m_valid_o = m_valid_q;
  assign status_o  = status_q;
  assign count_o   = count_q;

  // sequencing and commands
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    held_d    = held_q;
    res_d     = res_q;
    status_d  = status_q;
    count_d   = count_q;
    m_valid_d = m_valid_q & ~m_ready_i;
    cmd_o     = '{key_ld: 1'b0, idx_op: ssir_pkg::IDX_HOLD, cnt_op: ssir_pkg::CNT_HOLD,
                  pos_ld: 1'b0, rd_en: 1'b0, rd_sel: ssir_pkg::RD_IDX,
                  wr_en: 1'b0, wr_sel: ssir_pkg::WR_RDATA};
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.key_ld = 1'b1;
          cmd_o.idx_op = ssir_pkg::IDX_CLEAR;
          op_d         = op_i;
          state_d      = S_SCAN_CHK;
        end
      end
      // lower bound scan, each entry read in S_SCAN_CHK and compared in S_SCAN_CMP
      S_SCAN_CHK: begin
        if (stat_i.scan_end) begin
          held_d  = 1'b0;
          state_d = S_DECIDE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat_i.lt) begin
          cmd_o.idx_op = ssir_pkg::IDX_INC;
          state_d      = S_SCAN_CHK;
        end else begin
          held_d  = stat_i.eq;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.pos_ld = 1'b1;
        state_d      = S_RESULT;
        case (op_q)
          ssir_pkg::OP_SEARCH: begin
            res_d = held_q ? ssir_pkg::ST_OK : ssir_pkg::ST_ABSENT;
          end
          ssir_pkg::OP_INSERT: begin
            if (held_q) begin
              res_d = ssir_pkg::ST_DUP;
            end else if (stat_i.full) begin
              res_d = ssir_pkg::ST_FULL;
            end else begin
              cmd_o.idx_op = ssir_pkg::IDX_LOAD_CNT;
              state_d      = S_INS_CHK;
            end
          end
          ssir_pkg::OP_REMOVE: begin
            if (held_q) begin
              state_d = S_REM_CHK;
            end else begin
              res_d = ssir_pkg::ST_ABSENT;
            end
          end
          default: begin
            res_d = ssir_pkg::ST_ABSENT;
          end
        endcase
      end
      // shift entries up from the top down to the insert position
      S_INS_CHK: begin
        if (stat_i.idx_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ssir_pkg::RD_IDX_M1;
          state_d      = S_INS_WR;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ssir_pkg::WR_KEY;
          cmd_o.cnt_op = ssir_pkg::CNT_INC;
          res_d        = ssir_pkg::ST_OK;
          state_d      = S_RESULT;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = ssir_pkg::IDX_DEC;
        state_d      = S_INS_CHK;
      end
      // close the gap from the removed position upward
      S_REM_CHK: begin
        if (stat_i.rem_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ssir_pkg::RD_IDX_P1;
          state_d      = S_REM_WR;
        end else begin
          cmd_o.cnt_op = ssir_pkg::CNT_DEC;
          res_d        = ssir_pkg::ST_OK;
          state_d      = S_RESULT;
        end
      end
      S_REM_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = ssir_pkg::IDX_INC;
        state_d      = S_REM_CHK;
      end
      // load the output register once it is free
      S_RESULT: begin
        if (!m_valid_q || m_ready_i) begin
          m_valid_d = 1'b1;
          status_d  = res_q;
          count_d   = stat_i.cnt7;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      op_q      <= '0;
      held_q    <= 1'b0;
      res_q     <= ssir_pkg::ST_OK;
      status_q  <= ssir_pkg::ST_OK;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      op_q      <= op_d;
      held_q    <= held_d;
      res_q     <= res_d;
      status_q  <= status_d;
      count_q   <= count_d;
    end
  end

endmodule

/* sv/sorted_set_search_insert_remove.sv */
// top level of the sorted set with search, insert and remove
// Holds up to CAPACITY distinct signed 32-bit values in ascending order.
// Input channel s_axis: tuser carries the request (0 search, 1 insert,
// 2 remove), tdata the value. One transaction in gives one transaction out
// on m_axis: tdata carries the status (0 done or found, 1 not found,
// 2 duplicate, 3 full) and the number of values held after the request.
// Requests are served one at a time. The lower bound p is found by a linear
// scan of the single port entry memory with registered read, one read and
// one compare per entry below the value. Insert then moves each entry from
// the position upward, remove each entry above it, one read and one write
// per entry moved; a rejected insert or remove goes straight to its result
// like a search. The block is ready for the next request in the cycle after
// the result is registered. The result waits in an output register; the next
// request is taken while it waits, but its own result is held back until
// the receiver takes the earlier one, so a stalled receiver stalls the
// block after at most one request. Reset empties the set at once; no
// clearing pass is needed, entries above the count are never read.
module sorted_set_search_insert_remove #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] item_value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [1:0] status, [8:2] entry_count, [15:9] zero
);

  ssir_pkg::cmd_t  cmd;
  ssir_pkg::stat_t stat;
  logic [1:0]      status;
  logic [6:0]      entry_count;

  ssir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .op_i      (s_axis_tuser_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_o  (status),
    .count_o   (entry_count),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  ssir_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_value_i (s_axis_tdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

  // result packing
  assign m_axis_tdata_o = {7'd0, entry_count, status};

endmodule

/* tb/sv/tb.sv */
// testbench of the sorted set block: directed and random requests, scoreboard check
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CAPACITY       = 64;
  localparam int          RESET_CYCLES   = 6;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 300;
  localparam int          MIX_ITEMS      = 85;
  localparam int          PHASE_GUARD    = 400;
  localparam int          PRINT_LIMIT    = 100;
  // request code that the block does not define; it must answer not found
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  // idling modes of the traffic
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef logic signed [31:0] sval_t;

  typedef struct {
    ssir_pkg::status_e status;
    logic [6:0]        count;
  } set_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;  // [31:0] item_value
  logic [1:0]  s_axis_tuser_i  = '0;  // [1:0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // [1:0] status, [8:2] entry_count, [15:9] zero

  // predicted contents of the set, ascending
  sval_t       held_vals [CAPACITY];
  int          held_count = 0;
  set_result_t expected_results[$];
  sval_t       value_pool[48];

  int          error_count  = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int          quiet_cycles = 0;

  sorted_set_search_insert_remove #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    if (error_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // sorted set behavior: lower bound scan, then search, insert or remove
  function automatic set_result_t apply_request(logic [1:0] op, sval_t value);
    set_result_t res;
    int          pos;
    bit          held;
    pos = 0;
    while (pos < held_count && held_vals[pos] < value) pos++;
    held = (pos < held_count) && (held_vals[pos] == value);
    res.status = ssir_pkg::ST_ABSENT;
    case (op)
      ssir_pkg::OP_SEARCH: begin
        if (held) res.status = ssir_pkg::ST_OK;
      end
      ssir_pkg::OP_INSERT: begin
        if (held) begin
          res.status = ssir_pkg::ST_DUP;
        end else if (held_count >= CAPACITY) begin
          res.status = ssir_pkg::ST_FULL;
        end else begin
          for (int i = held_count; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = value;
          held_count++;
          res.status = ssir_pkg::ST_OK;
        end
      end
      ssir_pkg::OP_REMOVE: begin
        if (held) begin
          for (int i = pos; i + 1 < held_count; i++) held_vals[i] = held_vals[i+1];
          held_count--;
          res.status = ssir_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    res.count = 7'(held_count);
    return res;
  endfunction

  // one request transaction; prediction is made at the accepting edge
  task automatic send_request(logic [1:0] op, logic [31:0] value);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_results.push_back(apply_request(op, value));
  endtask

  task automatic check_result(logic [15:0] word);
    set_result_t exp;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %h with no request pending", word));
      return;
    end
    exp = expected_results.pop_front();
    if (word[1:0] != exp.status)
      report_mismatch($sformatf("status %0d, expected %0d", word[1:0], exp.status));
    if (word[8:2] != exp.count)
      report_mismatch($sformatf("entry_count %0d, expected %0d", word[8:2], exp.count));
    if (word[15:9] != '0)
      report_mismatch($sformatf("padding bits %h not zero", word[15:9]));
  endtask

  // result side: check each transaction, random backpressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void set_idle_mode(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 45; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 45; end
      default:       begin idle_pct = 12; stall_pct = 12; end
    endcase
  endfunction

  // value mix: a held value, a pool value that collides often, or any value
  function automatic logic [31:0] pick_value(int held_pct, int pool_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < held_pct && held_count > 0) return held_vals[$urandom_range(held_count - 1)];
    if (roll < held_pct + pool_pct) return value_pool[$urandom_range(47)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_op(int ins_pct, int rem_pct, int srch_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < ins_pct) return ssir_pkg::OP_INSERT;
    if (roll < ins_pct + rem_pct) return ssir_pkg::OP_REMOVE;
    if (roll < ins_pct + rem_pct + srch_pct) return ssir_pkg::OP_SEARCH;
    return OP_UNUSED;
  endfunction

  // requests on an empty set
  task automatic test_empty_set();
    send_request(ssir_pkg::OP_SEARCH, 32'h0000_0000);
    send_request(ssir_pkg::OP_REMOVE, 32'h8000_0000);
    send_request(OP_UNUSED, 32'h7fff_ffff);
    send_request(ssir_pkg::OP_SEARCH, 32'hffff_ffff);
  endtask

  // each operation on the extremes of the value range
  task automatic test_single_ops();
    send_request(ssir_pkg::OP_INSERT, 32'h0000_0000);
    send_request(ssir_pkg::OP_INSERT, 32'h7fff_ffff);
    send_request(ssir_pkg::OP_INSERT, 32'h8000_0000);
    send_request(ssir_pkg::OP_INSERT, 32'hffff_ffff);
    send_request(ssir_pkg::OP_INSERT, 32'h0000_0001);
    send_request(ssir_pkg::OP_INSERT, 32'h7fff_ffff);
    send_request(ssir_pkg::OP_INSERT, 32'h8000_0000);
    send_request(ssir_pkg::OP_SEARCH, 32'h8000_0000);
    send_request(ssir_pkg::OP_SEARCH, 32'h7fff_ffff);
    send_request(ssir_pkg::OP_SEARCH, 32'h8000_0001);
    send_request(ssir_pkg::OP_SEARCH, 32'h5555_aaaa);
    send_request(OP_UNUSED, 32'h0000_0000);
    send_request(ssir_pkg::OP_REMOVE, 32'h0000_0000);
    send_request(ssir_pkg::OP_REMOVE, 32'h0000_0000);
    send_request(ssir_pkg::OP_REMOVE, 32'h7fff_ffff);
    send_request(ssir_pkg::OP_REMOVE, 32'h8000_0000);
    send_request(ssir_pkg::OP_REMOVE, 32'hffff_ffff);
    send_request(ssir_pkg::OP_REMOVE, 32'h0000_0001);
    send_request(ssir_pkg::OP_SEARCH, 32'h0000_0001);
  endtask

  // insert-heavy traffic up to capacity, then the full store cases
  task automatic test_fill_to_capacity();
    logic [31:0] held_value;
    int          guard;
    guard = 0;
    while (held_count < CAPACITY && guard < PHASE_GUARD) begin
      send_request(pick_op(85, 5, 8), pick_value(10, 30));
      guard++;
    end
    send_request(ssir_pkg::OP_INSERT, $urandom);
    send_request(ssir_pkg::OP_INSERT, pick_value(0, 100));
    held_value = pick_value(100, 0);
    send_request(ssir_pkg::OP_INSERT, held_value);
    send_request(ssir_pkg::OP_SEARCH, held_value);
    send_request(OP_UNUSED, held_value);
    send_request(ssir_pkg::OP_REMOVE, held_value);
    send_request(ssir_pkg::OP_INSERT, held_value);
    send_request(ssir_pkg::OP_INSERT, $urandom);
  endtask

  // balanced traffic with random content
  task automatic test_mixed_traffic(int n_items);
    for (int i = 0; i < n_items; i++) send_request(pick_op(35, 30, 30), pick_value(40, 30));
  endtask

  // remove-heavy traffic until the set is empty
  task automatic test_drain_set();
    int guard;
    guard = 0;
    while (held_count > 0 && guard < PHASE_GUARD) begin
      send_request(pick_op(4, 80, 14), pick_value(85, 10));
      guard++;
    end
    send_request(ssir_pkg::OP_REMOVE, pick_value(0, 100));
    send_request(ssir_pkg::OP_SEARCH, pick_value(0, 100));
  endtask

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = 32'h8000_0001;
    value_pool[6] = 32'h7fff_fffe;
    for (int i = 7; i < 48; i++) value_pool[i] = $urandom;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idle_mode(IDLE_NONE);
    test_empty_set();
    test_single_ops();

    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      set_idle_mode(idle_mode_e'(m));
      test_fill_to_capacity();
      test_mixed_traffic(MIX_ITEMS);
      test_drain_set();
    end

    // all requests are in; wait for the last results
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
